// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/bvwr_pkg.sv -----
package bvwr_pkg;

    localparam int WORD_BITS = 64;
    localparam int MAX_WORDS = 4096;

    // fixed field widths
    localparam int DATA_W  = 64;
    localparam int BIL_W   = 7;
    localparam int CNT_W   = 19;
    localparam int FIRST_W = 18;

    localparam int LZ_W     = $clog2(WORD_BITS);
    localparam int PAD_BITS = 1 << LZ_W;
    localparam int PC_W     = $clog2(WORD_BITS + 1);
    localparam int POS_W    = $clog2(MAX_WORDS + 1);
    localparam int IDX_W    = POS_W + LZ_W;

    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic              last_word;
        logic [BIL_W-1:0]  bits_in_last;
    } t_in_req;

    typedef struct packed {
        logic [CNT_W-1:0]   set_count;
        logic               all_zero;
        logic               one_found;
        logic [FIRST_W-1:0] first_one_index;
    } t_out_req;

    // per-word scan result
    typedef struct packed {
        logic [PC_W-1:0] ones;
        logic            nonzero;
        logic [LZ_W-1:0] lead;
    } t_scan;

    // stage control toward the accumulator
    typedef struct packed {
        logic fire;
        logic last;
    } t_step;

endpackage

// ----- sv/bvwr_word_scan.sv -----
// Tail mask, popcount tree and leading-zero tree for one word.
module bvwr_word_scan (
    input  bvwr_pkg::t_in_req i_req,
    output bvwr_pkg::t_scan   o_scan
);

    logic [bvwr_pkg::WORD_BITS-1:0] w_keep;
    logic [bvwr_pkg::WORD_BITS-1:0] w_word;
    logic [bvwr_pkg::PAD_BITS-1:0]  w_pad;
    logic [bvwr_pkg::PC_W-1:0]      w_cnt  [bvwr_pkg::LZ_W+1][bvwr_pkg::PAD_BITS];
    logic                           w_zero [bvwr_pkg::LZ_W+1][bvwr_pkg::PAD_BITS];
    logic [bvwr_pkg::LZ_W-1:0]      w_lz   [bvwr_pkg::LZ_W+1][bvwr_pkg::PAD_BITS];

    always_comb begin
        // a short final word keeps only its top bits
        w_keep = '1;
        if (i_req.last_word && (i_req.bits_in_last != '0) &&
            (i_req.bits_in_last < bvwr_pkg::BIL_W'(bvwr_pkg::WORD_BITS))) begin
            w_keep = ~({bvwr_pkg::WORD_BITS{1'b1}} >> i_req.bits_in_last);
        end
        w_word = i_req.data_word[bvwr_pkg::WORD_BITS-1:0] & w_keep;

        w_pad = '0;
        w_pad[bvwr_pkg::PAD_BITS-1 -: bvwr_pkg::WORD_BITS] = w_word;

        for (int k = 0; k <= bvwr_pkg::LZ_W; k++) begin
            for (int j = 0; j < bvwr_pkg::PAD_BITS; j++) begin
                w_cnt[k][j]  = '0;
                w_zero[k][j] = 1'b1;
                w_lz[k][j]   = '0;
            end
        end

        for (int j = 0; j < bvwr_pkg::PAD_BITS; j++) begin
            w_cnt[0][j]  = bvwr_pkg::PC_W'(w_pad[j]);
            w_zero[0][j] = ~w_pad[j];
        end

        // node 2j+1 is the upper (lower-index) half
        for (int k = 0; k < bvwr_pkg::LZ_W; k++) begin
            for (int j = 0; j < bvwr_pkg::PAD_BITS / 2; j++) begin
                if (j < (bvwr_pkg::PAD_BITS >> (k + 1))) begin
                    w_cnt[k+1][j]  = w_cnt[k][2*j] + w_cnt[k][2*j+1];
                    w_zero[k+1][j] = w_zero[k][2*j] & w_zero[k][2*j+1];
                    if (w_zero[k][2*j+1]) begin
                        w_lz[k+1][j] = bvwr_pkg::LZ_W'(1 << k) | w_lz[k][2*j];
                    end else begin
                        w_lz[k+1][j] = w_lz[k][2*j+1];
                    end
                end
            end
        end

        o_scan.ones    = w_cnt[bvwr_pkg::LZ_W][0];
        o_scan.nonzero = ~w_zero[bvwr_pkg::LZ_W][0];
        o_scan.lead    = w_lz[bvwr_pkg::LZ_W][0];
    end

endmodule

// ----- sv/bvwr_accum.sv -----
// Running count, first-one tracking and the result register.
module bvwr_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bvwr_pkg::t_step    i_step,
    input  bvwr_pkg::t_scan    i_scan,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output bvwr_pkg::t_out_req o_out_data,
    output logic               o_out_free
);

    logic [bvwr_pkg::POS_W-1:0]   r_pos,   n_pos;
    logic [bvwr_pkg::CNT_W-1:0]   r_count, n_count;
    logic                         r_seen,  n_seen;
    logic [bvwr_pkg::FIRST_W-1:0] r_first, n_first;
    logic                         r_out_vld;
    bvwr_pkg::t_out_req           r_out,   n_out;

    logic                         w_in_range;
    logic                         w_take_first;
    logic [bvwr_pkg::IDX_W-1:0]   w_idx;

    always_comb begin
        w_in_range   = r_pos < bvwr_pkg::POS_W'(bvwr_pkg::MAX_WORDS);
        w_take_first = w_in_range && !r_seen && i_scan.nonzero;
        w_idx        = bvwr_pkg::IDX_W'(r_pos) * bvwr_pkg::IDX_W'(bvwr_pkg::WORD_BITS)
                     + bvwr_pkg::IDX_W'(i_scan.lead);

        n_count = r_count + (w_in_range ? bvwr_pkg::CNT_W'(i_scan.ones) : '0);
        n_seen  = r_seen | w_take_first;
        n_first = w_take_first ? bvwr_pkg::FIRST_W'(w_idx) : r_first;
        n_pos   = w_in_range ? r_pos + bvwr_pkg::POS_W'(1) : r_pos;

        n_out.set_count       = n_count;
        n_out.all_zero        = ~n_seen;
        n_out.one_found       = n_seen;
        n_out.first_one_index = n_seen ? n_first : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_count   <= '0;
            r_seen    <= 1'b0;
            r_first   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_step.fire) begin
                if (i_step.last) begin
                    r_pos   <= '0;
                    r_count <= '0;
                    r_seen  <= 1'b0;
                    r_first <= '0;
                end else begin
                    r_pos   <= n_pos;
                    r_count <= n_count;
                    r_seen  <= n_seen;
                    r_first <= n_first;
                end
            end
            if (i_step.fire && i_step.last) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.fire && i_step.last) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign o_out_free  = ~r_out_vld | i_out_ready;

endmodule

// ----- sv/bit_vector_word_reducer_unit.sv -----
// Bit-vector word reducer. Takes a bit vector as a stream of 64-bit words, lowest
// bit index in bit 63, and on the word flagged last_word (of which only the top
// bits_in_last bits count; 0 or 64 and above means the whole word) returns one result:
// the popcount of the vector, an all-zero flag, a found flag, and the index of
// the first set bit (word number * 64 + leading zeros of that word). Words that
// are not last return nothing. Words past the 4096th add nothing, but a last
// word still closes the vector. Throughput is one word per clock: each word sits
// in an input register, goes through the mask, popcount tree and leading-zero
// tree, and updates the running totals; a result appears on the output in the
// cycle after its last word is taken. The only stall is a last word in the
// input register while the previous result is still held unread in the output
// register.
`include "assert_macros.svh"

module bit_vector_word_reducer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bvwr_pkg::t_in_req  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bvwr_pkg::t_out_req o_out_data
);

    // input register
    logic              r_in_vld, n_in_vld;
    bvwr_pkg::t_in_req r_in;

    bvwr_pkg::t_scan   w_scan;
    bvwr_pkg::t_step   w_step;
    logic              w_out_free;
    logic              w_fire;

    // a non-last word never waits on the output side
    assign w_fire      = r_in_vld & (~r_in.last_word | w_out_free);
    assign o_in_ready  = ~r_in_vld | w_fire;
    assign w_step.fire = w_fire;
    assign w_step.last = r_in.last_word;
    assign n_in_vld    = o_in_ready ? i_in_valid : r_in_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    bvwr_word_scan u_scan (
        .i_req  (r_in),
        .o_scan (w_scan)
    );

    bvwr_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_scan      (w_scan),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_out_free  (w_out_free)
    );

    // flags in a result are always complementary
    `ASSERT_NOW(a_flags_excl, i_clk, i_rst_n, o_out_valid, o_out_data.all_zero != o_out_data.one_found)

    // an empty vector reports zero count and zero index
    `ASSERT_NOW(a_zero_result, i_clk, i_rst_n, o_out_valid && o_out_data.all_zero, (o_out_data.set_count == '0) && (o_out_data.first_one_index == '0))

    // a last word behind an unread result must stall the input side
    `ASSERT_NOW(a_last_stall, i_clk, i_rst_n, r_in_vld && r_in.last_word && o_out_valid && !i_out_ready, !o_in_ready)

    // a last word taken from the input register yields a result next cycle
    `ASSERT_NEXT(a_result_next, i_clk, i_rst_n, w_fire && r_in.last_word, o_out_valid)

endmodule
